@@ rtl/range_lock_table_top_macros.svh @@
`ifndef RANGE_LOCK_TABLE_TOP_MACROS_SVH
`define RANGE_LOCK_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define RLT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("range lock table check failed");

// next-cycle implication
`define RLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("range lock table check failed");

`endif

@@ rtl/rlt_pkg.sv @@
package rlt_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam int ADDR_W          = 64;
   localparam int STATUS_W        = 3;
   localparam int HELD_W          = 5;
   localparam int HELD_MAX        = 31;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_GRANTED   = 3'd0,
      STATUS_CONFLICT  = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_RELEASED  = 3'd3,
      STATUS_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic {
      MODE_LOCK   = 1'b0,
      MODE_UNLOCK = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      CTRL_IDLE    = 2'd0,
      CTRL_COMPARE = 2'd1,
      CTRL_COMMIT  = 2'd2
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic compare;
      logic commit;
   } cmd_type;

endpackage

@@ rtl/rlt_controller.sv @@
module rlt_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rlt_pkg::cmd_type  cmd
);

   rlt_pkg::ctrl_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlt_pkg::CTRL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.compare = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         rlt_pkg::CTRL_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = rlt_pkg::CTRL_COMPARE;
            end
         end
         rlt_pkg::CTRL_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = rlt_pkg::CTRL_COMMIT;
         end
         rlt_pkg::CTRL_COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               req_ready  = 1'b1;
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in    = rlt_pkg::CTRL_COMPARE;
               end else begin
                  state_in = rlt_pkg::CTRL_IDLE;
               end
            end
         end
         default: begin
            state_in = rlt_pkg::CTRL_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

@@ rtl/rlt_datapath.sv @@
module rlt_datapath #(
   parameter int ENTRIES = rlt_pkg::ENTRIES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rlt_pkg::cmd_type             cmd,
   input  logic                         req_mode,
   input  logic [rlt_pkg::ADDR_W-1:0]   req_range_start,
   input  logic [rlt_pkg::ADDR_W-1:0]   req_range_end,
   output logic [rlt_pkg::STATUS_W-1:0] rsp_status,
   output logic [rlt_pkg::HELD_W-1:0]   rsp_held_count
);

   localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CntW = $clog2(ENTRIES + 1);
   localparam int ExtW = CntW + rlt_pkg::HELD_W;

   logic                        mode_ff;
   logic [rlt_pkg::ADDR_W-1:0]  lo_ff, hi_ff;
   logic [rlt_pkg::ADDR_W-1:0]  start_ff [ENTRIES];
   logic [rlt_pkg::ADDR_W-1:0]  end_ff   [ENTRIES];
   logic [ENTRIES-1:0]          valid_ff, valid_in;
   logic [ENTRIES-1:0]          hit_vec_ff, hit_vec_in;
   logic [ENTRIES-1:0]          free_vec_ff;
   logic [CntW-1:0]             count_ff, count_in;
   rlt_pkg::status_type         status_ff, status_in;
   logic [rlt_pkg::HELD_W-1:0]  held_ff, held_in;
   logic [IdxW-1:0]             hit_idx, free_idx;
   logic                        hit_any, free_any, write_en;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         lo_ff   <= req_range_start;
         hi_ff   <= req_range_end;
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec_in[i] = valid_ff[i] && !(end_ff[i] < lo_ff || hi_ff < start_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         hit_vec_ff  <= hit_vec_in;
         free_vec_ff <= ~valid_ff;
      end
   end

   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec_ff[i]) begin
            hit_idx = IdxW'(i);
         end
         if (free_vec_ff[i]) begin
            free_idx = IdxW'(i);
         end
      end
   end

   assign hit_any  = |hit_vec_ff;
   assign free_any = |free_vec_ff;

   always_comb begin
      valid_in  = valid_ff;
      count_in  = count_ff;
      status_in = status_ff;
      write_en  = 1'b0;
      if (mode_ff == rlt_pkg::MODE_LOCK) begin
         priority if (hit_any) begin
            status_in = rlt_pkg::STATUS_CONFLICT;
         end else if (free_any) begin
            status_in          = rlt_pkg::STATUS_GRANTED;
            write_en           = 1'b1;
            valid_in[free_idx] = 1'b1;
            count_in           = count_ff + CntW'(1);
         end else begin
            status_in = rlt_pkg::STATUS_FULL;
         end
      end else begin
         if (hit_any) begin
            status_in         = rlt_pkg::STATUS_RELEASED;
            valid_in[hit_idx] = 1'b0;
            count_in          = count_ff - CntW'(1);
         end else begin
            status_in = rlt_pkg::STATUS_NOT_FOUND;
         end
      end
   end

   assign held_in = (ExtW'(count_in) > ExtW'(rlt_pkg::HELD_MAX))
                    ? rlt_pkg::HELD_W'(rlt_pkg::HELD_MAX)
                    : rlt_pkg::HELD_W'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (cmd.commit) begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && write_en) begin
         start_ff[free_idx] <= lo_ff;
         end_ff[free_idx]   <= hi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         held_ff   <= held_in;
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_held_count = held_ff;

endmodule

@@ rtl/range_lock_table_top.sv @@
// An accepted word is captured, compared against all slots, then committed to the result register.
// A new word can be taken while the last one commits, but not while it is being compared.
// The result register frees the input side while a response waits.
// Reset (synchronous, active high) empties the table and drops any response.
`include "range_lock_table_top_macros.svh"

module range_lock_table_top #(
   parameter int ENTRIES = rlt_pkg::ENTRIES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_mode,
   input  logic [rlt_pkg::ADDR_W-1:0]   req_range_start,
   input  logic [rlt_pkg::ADDR_W-1:0]   req_range_end,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [rlt_pkg::STATUS_W-1:0] rsp_status,
   output logic [rlt_pkg::HELD_W-1:0]   rsp_held_count
);

   rlt_pkg::cmd_type cmd;

   rlt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   rlt_datapath #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_mode        (req_mode),
      .req_range_start (req_range_start),
      .req_range_end   (req_range_end),
      .rsp_status      (rsp_status),
      .rsp_held_count  (rsp_held_count)
   );

   `RLT_ASSERT_NEXT(a_accept_then_compare, clock, reset, req_valid && req_ready, cmd.compare)
   `RLT_ASSERT_NOW(a_compare_not_commit, clock, reset, cmd.compare, !cmd.commit && !req_ready)
   `RLT_ASSERT_NOW(a_held_bounded, clock, reset, rsp_valid, 32'(rsp_held_count) <= ENTRIES)
   `RLT_ASSERT_NOW(a_granted_nonempty, clock, reset, rsp_valid && rsp_status == rlt_pkg::STATUS_GRANTED, rsp_held_count != '0)

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   localparam int SLOTS = rlt_pkg::ENTRIES_DEFAULT;
   localparam int RANDOM_WORDS = 1875;
   localparam int DIRECTED_ROWS = 27;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam logic [rlt_pkg::ADDR_W-1:0] TOP = '1;

   typedef struct packed {
      rlt_pkg::mode_type          mode;
      logic [rlt_pkg::ADDR_W-1:0] lo;
      logic [rlt_pkg::ADDR_W-1:0] hi;
      logic                       pinned;
      rlt_pkg::status_type        st;
      logic [rlt_pkg::HELD_W-1:0] held;
   } lock_req_type;

   typedef struct packed {
      rlt_pkg::status_type        st;
      logic [rlt_pkg::HELD_W-1:0] held;
   } outcome_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic                         req_mode;
   logic [rlt_pkg::ADDR_W-1:0]   req_range_start;
   logic [rlt_pkg::ADDR_W-1:0]   req_range_end;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic [rlt_pkg::STATUS_W-1:0] rsp_status;
   logic [rlt_pkg::HELD_W-1:0]   rsp_held_count;

   lock_req_type               stim[$];
   lock_req_type               directed_rows [DIRECTED_ROWS];
   lock_req_type               offered;
   outcome_type                lock_outcomes[$];
   outcome_type                seen;
   outcome_type                due;
   logic                       slot_held [SLOTS];
   logic [rlt_pkg::ADDR_W-1:0] slot_lo [SLOTS];
   logic [rlt_pkg::ADDR_W-1:0] slot_hi [SLOTS];
   int                         errors = 0;
   int                         words_taken = 0;
   int                         cycles = 0;
   bit                         stim_done = 1'b0;

   range_lock_table_top #(.ENTRIES(SLOTS)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_range_start(req_range_start),
      .req_range_end  (req_range_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_held_count (rsp_held_count)
   );

   always #6 clock = ~clock;

   function automatic bit spans_meet(logic [rlt_pkg::ADDR_W-1:0] a_lo,
                                     logic [rlt_pkg::ADDR_W-1:0] a_hi,
                                     logic [rlt_pkg::ADDR_W-1:0] b_lo,
                                     logic [rlt_pkg::ADDR_W-1:0] b_hi);
      return !(a_hi < b_lo || b_hi < a_lo);
   endfunction

   function automatic outcome_type lock_table_step(lock_req_type w);
      outcome_type o;
      int hit;
      int free_slot;
      int n;
      hit = -1;
      free_slot = -1;
      n = 0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (slot_held[i] && spans_meet(slot_lo[i], slot_hi[i], w.lo, w.hi))
            hit = i;
         if (!slot_held[i])
            free_slot = i;
      end
      if (w.mode == rlt_pkg::MODE_LOCK) begin
         if (hit >= 0) begin
            o.st = rlt_pkg::STATUS_CONFLICT;
         end else if (free_slot < 0) begin
            o.st = rlt_pkg::STATUS_FULL;
         end else begin
            slot_held[free_slot] = 1'b1;
            slot_lo[free_slot] = w.lo;
            slot_hi[free_slot] = w.hi;
            o.st = rlt_pkg::STATUS_GRANTED;
         end
      end else begin
         if (hit >= 0) begin
            slot_held[hit] = 1'b0;
            o.st = rlt_pkg::STATUS_RELEASED;
         end else begin
            o.st = rlt_pkg::STATUS_NOT_FOUND;
         end
      end
      for (int i = 0; i < SLOTS; i++)
         if (slot_held[i])
            n++;
      if (n > rlt_pkg::HELD_MAX)
         n = rlt_pkg::HELD_MAX;
      o.held = n[rlt_pkg::HELD_W-1:0];
      return o;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         due = lock_table_step(offered);
         if (offered.pinned) begin
            due.st = offered.st;
            due.held = offered.held;
         end
         lock_outcomes.push_back(due);
         words_taken++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (lock_outcomes.size() == 0) begin
            $error("unexpected response word: status %0d held_count %0d",
                   rsp_status, rsp_held_count);
            errors++;
         end else begin
            seen = lock_outcomes.pop_front();
            if (rsp_status !== seen.st) begin
               $error("status: expected %0d, got %0d", seen.st, rsp_status);
               errors++;
            end
            if (rsp_held_count !== seen.held) begin
               $error("held_count: expected %0d, got %0d", seen.held, rsp_held_count);
               errors++;
            end
         end
      end
   end

   initial begin : req_side
      lock_req_type w;
      int burst;
      int gap;
      req_valid = 1'b0;
      req_mode = rlt_pkg::MODE_LOCK;
      req_range_start = '0;
      req_range_end = '0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      while (stim.size() > 0) begin
         burst = $urandom_range(1, 30);
         for (int k = 0; k < burst && stim.size() > 0; k++) begin
            w = stim.pop_front();
            offered = w;
            req_valid <= 1'b1;
            req_mode <= w.mode;
            req_range_start <= w.lo;
            req_range_end <= w.hi;
            @(posedge clock);
            while (!req_ready)
               @(posedge clock);
            @(negedge clock);
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin : rsp_side
      int style;
      int span;
      bit held_off;
      held_off = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         style = $urandom_range(0, 3);
         span = $urandom_range(10, 80);
         for (int n = 0; n < span; n++) begin
            @(negedge clock);
            if (!held_off && words_taken >= 600) begin
               held_off = 1'b1;
               rsp_ready <= 1'b0;
               repeat (HOLD_OFF_CYCLES) @(negedge clock);
            end
            unique case (style)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= n[0];
               default: rsp_ready <= (n % 4 == 0);
            endcase
         end
      end
   end

   initial begin
      lock_req_type w;
      lock_req_type r;
      lock_req_type recent[$];
      logic [rlt_pkg::ADDR_W-1:0] pt;
      int lock_pct;
      int kind;
      reset = 1'b1;
      for (int i = 0; i < SLOTS; i++)
         slot_held[i] = 1'b0;

      directed_rows = '{
         '{rlt_pkg::MODE_UNLOCK, 64'd0, TOP, 1'b1, rlt_pkg::STATUS_NOT_FOUND, 5'd0},
         '{rlt_pkg::MODE_LOCK, 64'd0, 64'd0, 1'b1, rlt_pkg::STATUS_GRANTED, 5'd1},
         '{rlt_pkg::MODE_LOCK, 64'd0, 64'd0, 1'b1, rlt_pkg::STATUS_CONFLICT, 5'd1},
         '{rlt_pkg::MODE_LOCK, TOP, TOP, 1'b1, rlt_pkg::STATUS_GRANTED, 5'd2},
         '{rlt_pkg::MODE_LOCK, 64'd1, TOP - 64'd1, 1'b1, rlt_pkg::STATUS_GRANTED, 5'd3},
         '{rlt_pkg::MODE_UNLOCK, 64'd5, 64'd5, 1'b1, rlt_pkg::STATUS_RELEASED, 5'd2},
         '{rlt_pkg::MODE_LOCK, TOP - 64'd1, 64'd1, 1'b0, rlt_pkg::STATUS_GRANTED, 5'd0},
         '{rlt_pkg::MODE_UNLOCK, 64'd0, TOP, 1'b0, rlt_pkg::STATUS_GRANTED, 5'd0},
         '{rlt_pkg::MODE_UNLOCK, 64'd0, TOP, 1'b0, rlt_pkg::STATUS_GRANTED, 5'd0},
         '{rlt_pkg::MODE_UNLOCK, 64'd0, TOP, 1'b0, rlt_pkg::STATUS_GRANTED, 5'd0},
         '{rlt_pkg::MODE_LOCK, 64'h1000, 64'h1007, 1'b0, rlt_pkg::STATUS_GRANTED, 5'd0},
         '{rlt_pkg::MODE_LOCK, 64'h1010, 64'h1017, 1'b0, rlt_pkg::STATUS_GRANTED, 5'd0},
         '{rlt_pkg::MODE_LOCK, 64'h1020, 64'h1027, 1'b0, rlt_pkg::STATUS_GRANTED, 5'd0},
         '{rlt_pkg::MODE_LOCK, 64'h1030, 64'h1037, 1'b0, rlt_pkg::STATUS_GRANTED, 5'd0},
         '{rlt_pkg::MODE_LOCK, 64'h1040, 64'h1047, 1'b0, rlt_pkg::STATUS_GRANTED, 5'd0},
         '{rlt_pkg::MODE_LOCK, 64'h1050, 64'h1057, 1'b0, rlt_pkg::STATUS_GRANTED, 5'd0},
         '{rlt_pkg::MODE_LOCK, 64'h1060, 64'h1067, 1'b0, rlt_pkg::STATUS_GRANTED, 5'd0},
         '{rlt_pkg::MODE_LOCK, 64'h1070, 64'h1077, 1'b0, rlt_pkg::STATUS_GRANTED, 5'd0},
         '{rlt_pkg::MODE_LOCK, 64'h1080, 64'h1087, 1'b0, rlt_pkg::STATUS_GRANTED, 5'd0},
         '{rlt_pkg::MODE_LOCK, 64'h1090, 64'h1097, 1'b0, rlt_pkg::STATUS_GRANTED, 5'd0},
         '{rlt_pkg::MODE_LOCK, 64'h10a0, 64'h10a7, 1'b0, rlt_pkg::STATUS_GRANTED, 5'd0},
         '{rlt_pkg::MODE_LOCK, 64'h10b0, 64'h10b7, 1'b0, rlt_pkg::STATUS_GRANTED, 5'd0},
         '{rlt_pkg::MODE_LOCK, 64'h10c0, 64'h10c7, 1'b0, rlt_pkg::STATUS_GRANTED, 5'd0},
         '{rlt_pkg::MODE_LOCK, 64'h10d0, 64'h10d7, 1'b0, rlt_pkg::STATUS_GRANTED, 5'd0},
         '{rlt_pkg::MODE_LOCK, 64'h10e0, 64'h10e7, 1'b0, rlt_pkg::STATUS_GRANTED, 5'd0},
         '{rlt_pkg::MODE_LOCK, 64'h10f0, 64'h10f7, 1'b0, rlt_pkg::STATUS_GRANTED, 5'd0},
         '{rlt_pkg::MODE_LOCK, 64'h2000, 64'h2000, 1'b1, rlt_pkg::STATUS_FULL, 5'd16}
      };
      for (int i = 0; i < DIRECTED_ROWS; i++)
         stim.push_back(directed_rows[i]);

      lock_pct = 50;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 100 == 0)
            lock_pct = 25 + 30 * $urandom_range(0, 2);
         w = '0;
         w.mode = ($urandom_range(1, 100) <= lock_pct) ? rlt_pkg::MODE_LOCK
                                                       : rlt_pkg::MODE_UNLOCK;
         kind = $urandom_range(0, 9);
         if (w.mode == rlt_pkg::MODE_UNLOCK && recent.size() > 0 && $urandom_range(0, 1)) begin
            r = recent[$urandom_range(0, recent.size() - 1)];
            pt = r.lo + rlt_pkg::ADDR_W'($urandom_range(0, 3));
            w.lo = $urandom_range(0, 1) ? r.lo : pt;
            w.hi = $urandom_range(0, 1) ? r.hi : pt;
         end else begin
            unique case (kind)
               0, 1, 2, 3, 4, 5: begin
                  w.lo = rlt_pkg::ADDR_W'($urandom_range(0, 1023));
                  w.hi = w.lo + rlt_pkg::ADDR_W'($urandom_range(0, 24));
               end
               6: begin
                  w.lo = {$urandom, $urandom};
                  w.hi = {$urandom, $urandom};
               end
               7: begin
                  w.hi = rlt_pkg::ADDR_W'($urandom_range(0, 1023));
                  w.lo = w.hi + rlt_pkg::ADDR_W'($urandom_range(1, 40));
               end
               8: begin
                  w.lo = TOP - rlt_pkg::ADDR_W'($urandom_range(0, 40));
                  w.hi = TOP - rlt_pkg::ADDR_W'($urandom_range(0, 40));
               end
               default: begin
                  w.lo = {$urandom, $urandom};
                  w.hi = w.lo + rlt_pkg::ADDR_W'($urandom_range(0, 4096));
               end
            endcase
         end
         if (w.mode == rlt_pkg::MODE_LOCK) begin
            recent.push_back(w);
            if (recent.size() > 24)
               void'(recent.pop_front());
         end
         stim.push_back(w);
      end

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      while (!stim_done)
         @(posedge clock);
      while (lock_outcomes.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0 && lock_outcomes.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
